/* sv/swmv_pkg.sv */
// shared types and constants of the sliding window mean and variance unit
`default_nettype none
package swmv_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_LEN  = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_BIAS = 2'd1;
    localparam logic [1:0] CFG_PAST_MODE   = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned WLEN_W     = 11;
    localparam int unsigned RAW_W      = 16;
    localparam int unsigned PCNT_W     = 11;
    localparam int unsigned MEAN_W     = 16;
    localparam int unsigned VAR_W      = 31;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 64;
    localparam logic [10:0] WLEN_RESET = 11'd100;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RDOLD,
        ST_UPD,
        ST_MUL,
        ST_DIVM,
        ST_DIVV,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

/* sv/sliding_window_mean_variance_unit.sv */
// top level of the sliding window mean and variance unit
`default_nettype none
// Sliding window mean and variance of one bias-corrected sample stream.
// Input stream (s_axis_*): one transaction carries a raw sample and a past
// count. Output stream (m_axis_*): one transaction per input, carrying the
// corrected sample, the mean and the population variance.
// Config channel (i_cfg_*): register index and data, always ready. Writing
// window_len clears the sample ring and the sums.
// Per item the sequencer runs: walk of k stored samples in past mode (one
// memory read per cycle, k = min(past_count, window)), read of the oldest
// slot, read-modify-write of the ring and sums, a serial c*q multiply and
// two restoring divisions (mean, then variance) on the shared divider. In
// past mode with k zero the multiply and divisions are skipped and the
// previous mean and variance are sent again.
// A new item is taken while the previous result still waits in the output
// register; the result stage waits only when that register is still full.
// After reset and after each window_len write a clearing pass writes zeros
// to all MAX_WINDOW ring entries, one per cycle, with s_axis_tready low.
// A stalled receiver holds the output transaction stable until taken.
module sliding_window_mean_variance_unit #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] raw_sample, [26:16] past_count, rest zero
    input  wire [swmv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // [15:0] corrected_sample, [31:16] window_mean, [62:32] window_variance
    output logic [swmv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [swmv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [swmv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import swmv_pkg::*;

    localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W + 1;
    localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W;
    localparam int PROD_W  = CNT_W + SQ_W;
    localparam int REM_W   = 2 * CNT_W + 1;
    localparam int WIDE_W  = PROD_W + 2 * SUM_W;
    localparam int DCNT_W  = $clog2(PROD_W + 1);
    localparam int MCNT_W  = $clog2(CNT_W + 1);

    // sample memory
    logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    logic                          wr_en;

    t_state r_state, n_state;

    // configuration
    logic [WLEN_W-1:0]        r_wlen;
    logic signed [RAW_W-1:0]  r_bias;
    logic                     r_past;

    // item registers
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [CNT_W-1:0]              r_n;
    logic [CNT_W-1:0]              r_c;
    logic [CNT_W-1:0]              r_left;
    logic [AW-1:0]                 r_slot;
    logic [AW-1:0]                 r_idx;
    logic [AW-1:0]                 r_clr;
    logic                          r_acc_pend;
    logic signed [SUM_W-1:0]       r_sum, r_s;
    logic signed [SQ_W-1:0]        r_sq, r_q;
    logic signed [SUM_W-1:0]       r_ms;

    // serial multiplier
    logic [CNT_W-1:0]         r_mc;
    logic [PROD_W-1:0]        r_mq;
    logic [PROD_W-1:0]        r_prod;
    logic [MCNT_W-1:0]        r_mcnt;
    logic [2*SUM_W-1:0]       r_ss;

    // shared restoring divider
    logic [PROD_W-1:0]        r_dvd;
    logic [PROD_W-1:0]        r_quo;
    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         r_div;
    logic [DCNT_W-1:0]        r_dcnt;
    logic                     r_neg;

    logic signed [SAMPLE_BITS-1:0] r_hmean;
    logic [VAR_W-1:0]              r_hvar;

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;

    // input decode and saturation
    logic signed [RAW_W-1:0]  raw;
    logic [PCNT_W-1:0]        pcnt;
    logic signed [31:0]       x_full;
    logic signed [31:0]       smax, smin;
    logic signed [SAMPLE_BITS-1:0] x_sat;
    logic [CNT_W-1:0]         eff_n;
    logic [CNT_W-1:0]         k_sel;
    logic                     in_acc, cfg_acc;

    assign raw    = s_axis_tdata[RAW_W-1:0];
    assign pcnt   = s_axis_tdata[RAW_W+PCNT_W-1:RAW_W];
    assign x_full = 32'(raw) - 32'(r_bias);
    assign smax   = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
    assign smin   = -(32'sd1 <<< (SAMPLE_BITS - 1));

    always_comb begin
        priority if (x_full > smax) begin
            x_sat = SAMPLE_BITS'(smax);
        end else if (x_full < smin) begin
            x_sat = SAMPLE_BITS'(smin);
        end else begin
            x_sat = SAMPLE_BITS'(x_full);
        end
    end

    // window length clamped to 1..MAX_WINDOW
    always_comb begin
        priority if (r_wlen == '0) begin
            eff_n = CNT_W'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            eff_n = CNT_W'(MAX_WINDOW);
        end else begin
            eff_n = CNT_W'(r_wlen);
        end
    end

    assign k_sel = (32'(pcnt) > 32'(eff_n)) ? eff_n : CNT_W'(pcnt);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid;

    // walk address and oldest slot
    logic [AW-1:0] idx_prev;
    logic [AW-1:0] slot_wrap;
    logic [AW-1:0] slot_next;
    assign idx_prev  = (r_idx == '0) ? AW'(r_n - CNT_W'(1)) : r_idx - AW'(1);
    assign slot_wrap = (32'(r_slot) >= 32'(eff_n)) ? '0 : r_slot;
    assign slot_next = (32'(r_slot) + 1 >= 32'(r_n)) ? '0 : r_slot + AW'(1);

    // ring update arithmetic
    logic signed [SUM_W-1:0]         upd_sum;
    logic signed [SQ_W-1:0]          upd_sq;
    logic signed [2*SAMPLE_BITS-1:0] x_sq, old_sq, rd_sq;
    assign x_sq    = r_x * r_x;
    assign old_sq  = r_rd_data * r_rd_data;
    assign rd_sq   = old_sq;
    assign upd_sum = r_sum + SUM_W'(r_x) - SUM_W'(r_rd_data);
    assign upd_sq  = r_sq + SQ_W'(x_sq) - SQ_W'(old_sq);

    // divider step
    logic [REM_W-1:0] trial;
    logic             fits;
    assign trial = {r_rem[REM_W-2:0], r_dvd[PROD_W-1]};
    assign fits  = (trial >= r_div);

    // variance numerator
    logic signed [WIDE_W-1:0] num;
    logic [SUM_W-1:0]         abs_s;
    logic [2*SUM_W-1:0]       s_sq;
    assign num   = $signed(WIDE_W'(r_prod)) - $signed(WIDE_W'(r_ss));
    assign abs_s = r_ms[SUM_W-1] ? SUM_W'(-r_ms) : SUM_W'(r_ms);
    // square of the sum magnitude, full width
    assign s_sq  = {{SUM_W{1'b0}}, abs_s} * {{SUM_W{1'b0}}, abs_s};

    logic [31:0] x_ext, m_ext;
    assign x_ext = 32'(r_x);
    assign m_ext = 32'(r_hmean);

    // memory ports
    always_comb begin
        unique case (r_state)
            ST_WALK:  rd_addr = idx_prev;
            default:  rd_addr = r_slot;
        endcase
        wr_en   = (r_state == ST_CLEAR) || (r_state == ST_UPD);
        wr_addr = (r_state == ST_CLEAR) ? r_clr : r_slot;
        wr_data = (r_state == ST_CLEAR) ? '0 : r_x;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (32'(r_clr) == MAX_WINDOW - 1) n_state = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_past && k_sel != '0) ? ST_WALK : ST_RDOLD;
                end
            end
            ST_WALK:  if (r_left == CNT_W'(1)) n_state = ST_RDOLD;
            ST_RDOLD: n_state = ST_UPD;
            ST_UPD:   n_state = (r_past && r_c == '0) ? ST_FIN : ST_MUL;
            ST_MUL:   if (32'(r_mcnt) == CNT_W - 1) n_state = ST_DIVM;
            ST_DIVM:  if (32'(r_dcnt) == PROD_W - 1) n_state = ST_DIVV;
            ST_DIVV:  if (32'(r_dcnt) == PROD_W - 1) n_state = ST_FIN;
            ST_FIN:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
        if (cfg_acc && i_cfg_index == CFG_WINDOW_LEN) begin
            n_state = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= WLEN_RESET;
            r_bias      <= '0;
            r_past      <= 1'b0;
            r_clr       <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_hmean     <= '0;
            r_hvar      <= '0;
            r_acc_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_acc_pend <= (r_state == ST_WALK);
            if (r_acc_pend) begin
                r_s <= r_s + SUM_W'(r_rd_data);
                r_q <= r_q + SQ_W'(rd_sq);
            end

            unique case (r_state)
                ST_CLEAR: r_clr <= r_clr + AW'(1);
                ST_IDLE: begin
                    if (in_acc) begin
                        r_x    <= x_sat;
                        r_n    <= eff_n;
                        r_slot <= slot_wrap;
                        r_idx  <= slot_wrap;
                        r_left <= k_sel;
                        r_c    <= r_past ? k_sel : eff_n;
                        r_s    <= '0;
                        r_q    <= '0;
                    end
                end
                ST_WALK: begin
                    r_idx  <= idx_prev;
                    r_left <= r_left - CNT_W'(1);
                end
                ST_RDOLD: ;
                ST_UPD: begin
                    r_sum  <= upd_sum;
                    r_sq   <= upd_sq;
                    r_slot <= slot_next;
                    r_ms     <= r_past ? r_s : upd_sum;
                    r_mc   <= r_c;
                    r_mq   <= PROD_W'(r_past ? SQ_W'(r_q) : SQ_W'(upd_sq));
                    r_prod <= '0;
                    r_mcnt <= '0;
                end
                ST_MUL: begin
                    r_ss   <= s_sq;
                    if (r_mc[0]) r_prod <= r_prod + r_mq;
                    r_mc   <= r_mc >> 1;
                    r_mq   <= r_mq << 1;
                    r_mcnt <= r_mcnt + MCNT_W'(1);
                    if (32'(r_mcnt) == CNT_W - 1) begin
                        r_dvd  <= PROD_W'(abs_s);
                        r_div  <= REM_W'(r_c);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dcnt <= '0;
                        r_neg  <= r_ms[SUM_W-1];
                    end
                end
                ST_DIVM, ST_DIVV: begin
                    r_rem  <= fits ? trial - r_div : trial;
                    r_quo  <= {r_quo[PROD_W-2:0], fits};
                    r_dvd  <= r_dvd << 1;
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                    if (32'(r_dcnt) == PROD_W - 1) begin
                        if (r_state == ST_DIVM) begin
                            r_hmean <= r_neg ? -SAMPLE_BITS'({r_quo[PROD_W-2:0], fits})
                                             : SAMPLE_BITS'({r_quo[PROD_W-2:0], fits});
                            r_dvd   <= (num > 0) ? PROD_W'(num) : '0;
                            r_div   <= REM_W'(r_c * r_c);
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_dcnt  <= '0;
                        end else begin
                            r_hvar <= VAR_W'({r_quo[PROD_W-2:0], fits});
                        end
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, r_hvar, m_ext[MEAN_W-1:0],
                                        x_ext[RAW_W-1:0]};
                    end
                end
                default: ;
            endcase

            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_WINDOW_LEN: begin
                        r_wlen <= i_cfg_data[WLEN_W-1:0];
                        r_clr  <= '0;
                        r_slot <= '0;
                        r_sum  <= '0;
                        r_sq   <= '0;
                    end
                    CFG_SAMPLE_BIAS: r_bias <= $signed(i_cfg_data);
                    CFG_PAST_MODE:   r_past <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// testbench of the sliding window mean and variance unit
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import swmv_pkg::*;

    typedef struct packed {
        logic [15:0] corrected;
        logic [15:0] mean;
        logic [30:0] variance;
    } t_result;

    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  index;
        logic [15:0] value;
        logic [15:0] raw;
        logic [10:0] pcount;
    } t_job;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sliding_window_mean_variance_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // own copy of the window state
    logic signed [15:0] ring [0:1023];
    int unsigned slot;
    longint run_sum, run_sq;
    logic signed [15:0] last_mean;
    logic [30:0] last_var;
    logic [10:0] wlen;
    logic signed [15:0] bias;
    logic pmode;

    t_job    pending [$];
    t_result expected_results [$];
    int mismatches = 0;
    int results_seen = 0;
    int past_items = 0;
    bit quiet_tail = 0;
    bit all_sent = 0;

    function automatic void clear_window();
        for (int i = 0; i < 1024; i++) ring[i] = '0;
        slot = 0; run_sum = 0; run_sq = 0;
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_WINDOW_LEN: begin
                wlen = val[10:0];
                clear_window();
            end
            CFG_SAMPLE_BIAS: bias = val;
            CFG_PAST_MODE: pmode = val[0];
            default: ;
        endcase
    endfunction

    function automatic void mean_var(longint s, longint q, longint c);
        longint num;
        num = c * q - s * s;
        last_mean = 16'(s / c);
        last_var = (num > 0) ? 31'(num / (c * c)) : '0;
    endfunction

    // corrected sample, ring update and mean/variance for one sample
    function automatic t_result predict_stats(logic [15:0] raw, logic [10:0] pc);
        t_result r;
        int unsigned n, k, idx;
        longint x, old, s, q, v;
        n = (wlen == 0) ? 1 : (wlen > 1024) ? 1024 : wlen;
        x = longint'($signed(raw)) - longint'(bias);
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (slot >= n) slot = 0;
        if (pmode) begin
            k = (pc > n) ? n : pc;
            if (k != 0) begin
                s = 0; q = 0; idx = slot;
                for (int i = 0; i < k; i++) begin
                    idx = (idx == 0) ? n - 1 : idx - 1;
                    v = ring[idx];
                    s += v; q += v * v;
                end
                mean_var(s, q, k);
            end
        end
        old = ring[slot];
        run_sum += x - old;
        run_sq += x * x - old * old;
        ring[slot] = 16'(x);
        slot = (slot + 1 >= n) ? 0 : slot + 1;
        if (!pmode) mean_var(run_sum, run_sq, n);
        r.corrected = 16'(x);
        r.mean = last_mean;
        r.variance = last_var;
        return r;
    endfunction

    function automatic void add_sample(logic [15:0] raw, logic [10:0] pc);
        t_job j;
        j = '0; j.raw = raw; j.pcount = pc;
        pending.push_back(j);
    endfunction

    function automatic void add_write(logic [1:0] idx, logic [15:0] val);
        t_job j;
        j = '0; j.is_cfg = 1'b1; j.index = idx; j.value = val;
        pending.push_back(j);
    endfunction

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [10:0] rand_count();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'($urandom);
            2: return 11'd1024;
            default: return 11'($urandom_range(1, 24));
        endcase
    endfunction

    // driver: one transaction at a time, config only when the block is idle
    int gap = 0;
    int idle_wait = 0;
    bit in_done = 1'b0;
    bit cfg_done = 1'b0;

    // handshakes complete at the rising edge
    always @(posedge i_clk) begin
        in_done <= i_rst_n && s_axis_tvalid && s_axis_tready;
        cfg_done <= i_rst_n && i_cfg_valid && o_cfg_ready;
    end

    always @(negedge i_clk) begin
        t_job j;
        bit busy, next_in, next_cfg;
        busy = (s_axis_tvalid && !in_done) || (i_cfg_valid && !cfg_done);
        next_in = 1'b0;
        next_cfg = 1'b0;
        if (!i_rst_n || busy) begin
            next_in = s_axis_tvalid;
            next_cfg = i_cfg_valid;
        end else if (gap > 0) begin
            gap <= gap - 1;
        end else if (pending.size() == 0) begin
            all_sent <= 1'b1;
        end else if (pending[0].is_cfg) begin
            // wait for all results and a quiet spell before touching registers
            if (expected_results.size() != 0 || s_axis_tvalid) begin
                idle_wait <= 0;
            end else if (idle_wait < 300) begin
                idle_wait <= idle_wait + 1;
            end else begin
                j = pending.pop_front();
                apply_register(j.index, j.value);
                next_cfg = 1'b1;
                i_cfg_index <= j.index;
                i_cfg_data <= j.value;
                idle_wait <= 0;
            end
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            gap <= $urandom_range(1, 10);
        end else begin
            j = pending.pop_front();
            if (pmode) past_items++;
            expected_results.push_back(predict_stats(j.raw, j.pcount));
            next_in = 1'b1;
            s_axis_tdata <= {5'b0, j.pcount, j.raw};
        end
        s_axis_tvalid <= next_in;
        i_cfg_valid <= next_cfg;
    end

    // receiver stalls in bursts
    int stall = 0;
    always @(negedge i_clk) begin
        if (quiet_tail) begin
            m_axis_tready <= 1'b1;
        end else if (stall > 0) begin
            stall <= stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall <= $urandom_range(1, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_result got, want;
            got.corrected = m_axis_tdata[15:0];
            got.mean = m_axis_tdata[31:16];
            got.variance = m_axis_tdata[62:32];
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", m_axis_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                            results_seen, $signed(want.corrected), $signed(want.mean),
                            want.variance, $signed(got.corrected), $signed(got.mean),
                            got.variance);
                end
            end
        end
    end

    initial begin
        wlen = WLEN_RESET; bias = '0; pmode = 1'b0;
        clear_window();
        last_mean = '0; last_var = '0;

        // directed: extremes, saturation both ways, past mode corner counts
        add_sample(16'h7FFF, 11'd0);
        add_sample(16'h8000, 11'h7FF);
        add_sample(16'h0000, 11'd5);
        add_write(CFG_SAMPLE_BIAS, 16'h8000);
        add_sample(16'h7FFF, 11'd0);
        add_sample(16'h0001, 11'd0);
        add_write(CFG_SAMPLE_BIAS, 16'h7FFF);
        add_sample(16'h8000, 11'd0);
        add_sample(16'hFFFF, 11'd0);
        add_write(CFG_WINDOW_LEN, 16'd1);
        add_sample(16'h1234, 11'd0);
        add_write(CFG_PAST_MODE, 16'd1);
        add_sample(16'h0010, 11'd0);
        add_sample(16'h0020, 11'd1);
        add_sample(16'h0030, 11'd2047);
        add_write(CFG_WINDOW_LEN, 16'd4);
        add_write(CFG_SAMPLE_BIAS, 16'd0);
        for (int i = 0; i < 6; i++) add_sample(16'(i * 1000 - 2500), 11'(i));
        add_write(CFG_WINDOW_LEN, 16'd0);
        add_sample(16'h4000, 11'd3);
        add_write(CFG_WINDOW_LEN, 16'h7FF);
        add_sample(16'h8000, 11'd1024);
        add_write(CFG_WINDOW_LEN, 16'h0FFF);

        // random phases over several settings
        for (int p = 0; p < 10; p++) begin
            logic [15:0] wl;
            case (p % 4)
                0: wl = 16'($urandom_range(1, 8));
                1: wl = 16'($urandom_range(9, 40));
                2: wl = (p == 2) ? 16'd1024 : 16'd1;
                default: wl = 16'($urandom);
            endcase
            if (p == 6) wl = 16'd1025;
            add_write(CFG_WINDOW_LEN, wl);
            add_write(CFG_SAMPLE_BIAS, ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(0, 30)));
            add_write(CFG_PAST_MODE, 16'(p % 2));
            for (int i = 0; i < 48; i++) add_sample(rand_raw(), rand_count());
        end
        add_write(CFG_PAST_MODE, 16'd1);
        add_write(CFG_PAST_MODE, 16'($urandom) | 16'hFFFE);
        add_write(CFG_WINDOW_LEN, 16'd12);
        add_write(CFG_SAMPLE_BIAS, 16'($urandom));
        add_write(CFG_PAST_MODE, 16'd0);
        for (int i = 0; i < 30; i++) add_sample(rand_raw(), rand_count());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending.size() < 40);
        quiet_tail = 1;
        wait (all_sent && !s_axis_tvalid && expected_results.size() == 0);
        repeat (3000) @(posedge i_clk);
        $display("covered %0d results, %0d of them in past mode, over several window,",
                 results_seen, past_items);
        $display("bias and mode settings with random source and sink stalls");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
